>>> sv/bab_pkg.sv
// Shared constants, types and helper function of the bounding box block.
package bab_pkg;

  localparam int MAX_POINTS  = 32;
  localparam int COORD_WIDTH = 24;
  localparam int MARGIN_W    = 23;
  localparam int VAL_W       = 25;
  localparam int IDX_W       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int SUM_W       = ((COORD_WIDTH > MARGIN_W + 1) ? COORD_WIDTH : MARGIN_W + 1) + 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_Z  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_EN = 2'd3;

  localparam logic KIND_BOX   = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  localparam logic signed [SUM_W-1:0] SUM_VAL_MAX = SUM_W'((2 ** VAL_W) - 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [MARGIN_W-1:0] margin_t;
  typedef logic [VAL_W-1:0] value_t;

  typedef struct packed {
    logic accept;
    logic box_load;
    logic rd_issue;
    logic pt_load;
    logic idx_inc;
    logic clear_run;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic center_en;
    logic cnt_zero;
    logic last_idx;
  } dp_status_t;

  function automatic value_t clamp_value(input logic signed [SUM_W-1:0] v);
    value_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > SUM_VAL_MAX) begin
      r = {VAL_W{1'b1}};
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/bab_ctrl.sv
// Sequencer for point loading, box output and the replay of stored points.
module bab_ctrl import bab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       final_point_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_BOX  = 4'b0010,
    S_RD   = 4'b0100,
    S_PT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (final_point_i) state_d = S_BOX;
        end
      end
      S_BOX: begin
        if (status_i.out_free) begin
          cmd_o.box_load = 1'b1;
          if (!status_i.center_en || status_i.cnt_zero) begin
            cmd_o.clear_run = 1'b1;
            state_d         = S_LOAD;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_PT;
      end
      S_PT: begin
        if (status_i.out_free) begin
          cmd_o.pt_load = 1'b1;
          if (status_i.last_idx) begin
            cmd_o.clear_run = 1'b1;
            state_d         = S_LOAD;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/bab_dp.sv
// Configuration registers, point store, corner tracking, length and shift arithmetic, output register.
module bab_dp import bab_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MARGIN_W-1:0]  cfg_data_i,
  input  logic [COORD_WIDTH-1:0] coord_x_i,
  input  logic [COORD_WIDTH-1:0] coord_y_i,
  input  logic [COORD_WIDTH-1:0] coord_z_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 item_kind_o,
  output logic [VAL_W-1:0]     value_x_o,
  output logic [VAL_W-1:0]     value_y_o,
  output logic [VAL_W-1:0]     value_z_o,
  output logic                 overflow_o,
  output logic                 end_of_run_o
);

  coord_t  lo_q [3];
  coord_t  hi_q [3];
  coord_t  pt   [3];
  coord_t  rd_pt [3];
  margin_t margin_q [3];
  logic    center_en_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             ovf_q;
  logic             first;
  logic [3*COORD_WIDTH-1:0] mem_q [MAX_POINTS];
  logic [3*COORD_WIDTH-1:0] rd_data_q;

  value_t box_val [3];
  value_t pt_val  [3];

  logic   out_valid_q, kind_q, ovf_out_q, eor_q;
  value_t val_q [3];

  assign pt[0] = coord_x_i;
  assign pt[1] = coord_y_i;
  assign pt[2] = coord_z_i;
  assign rd_pt[0] = rd_data_q[COORD_WIDTH-1:0];
  assign rd_pt[1] = rd_data_q[2*COORD_WIDTH-1:COORD_WIDTH];
  assign rd_pt[2] = rd_data_q[3*COORD_WIDTH-1:2*COORD_WIDTH];

  assign first = (cnt_q == '0) && !ovf_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q[0] <= '0;
      margin_q[1] <= '0;
      margin_q[2] <= '0;
      center_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MARGIN_X:  margin_q[0] <= cfg_data_i;
        CFG_MARGIN_Y:  margin_q[1] <= cfg_data_i;
        CFG_MARGIN_Z:  margin_q[2] <= cfg_data_i;
        CFG_CENTER_EN: center_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Run state: corners, fill count, overflow flag, replay index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < 3; m++) begin
        lo_q[m] <= '0;
        hi_q[m] <= '0;
      end
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      rd_idx_q <= '0;
    end else if (cmd_i.clear_run) begin
      for (int m = 0; m < 3; m++) begin
        lo_q[m] <= '0;
        hi_q[m] <= '0;
      end
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        for (int m = 0; m < 3; m++) begin
          if (first || pt[m] < lo_q[m]) lo_q[m] <= pt[m];
          if (first || pt[m] > hi_q[m]) hi_q[m] <= pt[m];
        end
        if (cnt_q < CNT_W'(MAX_POINTS)) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.idx_inc) rd_idx_q <= rd_idx_q + IDX_W'(1);
    end
  end

  // Point store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (cnt_q < CNT_W'(MAX_POINTS))) begin
      mem_q[cnt_q[IDX_W-1:0]] <= {coord_z_i, coord_y_i, coord_x_i};
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      box_val[m] = clamp_value(SUM_W'(hi_q[m]) - SUM_W'(lo_q[m])
                               + $signed(SUM_W'({margin_q[m], 1'b0})));
      pt_val[m]  = clamp_value(SUM_W'(rd_pt[m]) - SUM_W'(lo_q[m])
                               + $signed(SUM_W'(margin_q[m])));
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.box_load || cmd_i.pt_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.box_load) begin
      kind_q    <= KIND_BOX;
      val_q     <= box_val;
      ovf_out_q <= ovf_q;
      eor_q     <= !center_en_q || (cnt_q == '0);
    end else if (cmd_i.pt_load) begin
      kind_q    <= KIND_POINT;
      val_q     <= pt_val;
      ovf_out_q <= ovf_q;
      eor_q     <= status_o.last_idx;
    end
  end

  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.center_en = center_en_q;
  assign status_o.cnt_zero  = (cnt_q == '0);
  assign status_o.last_idx  = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == cnt_q);

  assign out_valid_o  = out_valid_q;
  assign item_kind_o  = kind_q;
  assign value_x_o    = val_q[0];
  assign value_y_o    = val_q[1];
  assign value_z_o    = val_q[2];
  assign overflow_o   = ovf_out_q;
  assign end_of_run_o = eor_q;

endmodule

>>> sv/bounding_box_and_centering_top.sv
// Bounding box top: one point accepted per cycle while loading.
// After the final point is accepted, the box item is registered from S_BOX once the output is free.
// Each replayed point then takes a store read (S_RD) and an output load (S_PT).
// Input stays low after a final point until the box item and, with centering, every stored point are loaded.
// Reset clears corners, count, overflow, margins (center enable to 1);
// the point store needs no clearing and no pass runs after reset.
module bounding_box_and_centering_top import bab_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [MARGIN_W-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COORD_WIDTH-1:0] coord_x_i,
  input  logic [COORD_WIDTH-1:0] coord_y_i,
  input  logic [COORD_WIDTH-1:0] coord_z_i,
  input  logic                   final_point_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   item_kind_o,
  output logic [VAL_W-1:0]       value_x_o,
  output logic [VAL_W-1:0]       value_y_o,
  output logic [VAL_W-1:0]       value_z_o,
  output logic                   overflow_o,
  output logic                   end_of_run_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  bab_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .final_point_i (final_point_i),
    .in_ready_o    (in_ready_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  bab_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .item_kind_o  (item_kind_o),
    .value_x_o    (value_x_o),
    .value_y_o    (value_y_o),
    .value_z_o    (value_z_o),
    .overflow_o   (overflow_o),
    .end_of_run_o (end_of_run_o)
  );

endmodule
